[rtl/core/fbfl_pkg.sv]
// Shared types and constants of the fixed block free list allocator.
`default_nettype none
package fbfl_pkg;

  localparam int NumBlocksDefault = 256;

  localparam int ActionW  = 2;
  localparam int BlkIdxW  = 8;
  localparam int BaseW    = 32;
  localparam int BsizeW   = 13;
  localparam int AddrW    = 33;
  localparam int StatusW  = 2;
  localparam int UsedW    = 9;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;

  // Usage counter width. Repeated frees of one block can hand it out again and
  // again, so the count may run well past the pool size; only its low bits are
  // reported, but the empty check sees the whole count.
  localparam int UsedCntW = 32;

  localparam logic [BsizeW-1:0] BsizeReset = BsizeW'(8);

  localparam logic [ActionW-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ActionW-1:0] ACT_FREE  = 2'd1;
  localparam logic [ActionW-1:0] ACT_CLEAR = 2'd2;

  localparam logic [StatusW-1:0] STAT_OK  = 2'd0;
  localparam logic [StatusW-1:0] STAT_OOM = 2'd1;
  localparam logic [StatusW-1:0] STAT_BAD = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_POOL_BASE  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE = 1'd1;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  // Result fields other than the block index, which depends on the pool depth.
  typedef struct packed {
    logic               granted;
    logic [StatusW-1:0] status;
    logic [UsedW-1:0]   used;
  } res_t;

endpackage
`default_nettype wire

[rtl/core/fbfl_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module fbfl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [Width-1:0]   rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/core/fbfl_out_buf.sv]
// Two-entry result buffer that also forms the byte address of a granted block.
`default_nettype none
module fbfl_out_buf
  import fbfl_pkg::*;
#(
  parameter int IdxW = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [BaseW-1:0]   pool_base_i,
  input  wire logic [BsizeW-1:0]  block_size_i,
  input  wire logic               push_i,
  output logic                    push_ready_o,
  input  wire logic [IdxW-1:0]    push_idx_i,
  input  wire res_t               push_res_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [BlkIdxW-1:0]      granted_index_o,
  output logic [AddrW-1:0]        granted_address_o,
  output logic [StatusW-1:0]      status_o,
  output logic [UsedW-1:0]        blocks_used_o
);

  typedef struct packed {
    logic [BlkIdxW-1:0] idx;
    logic [AddrW-1:0]   addr;
    logic [StatusW-1:0] status;
    logic [UsedW-1:0]   used;
  } entry_t;

  entry_t new_entry;
  entry_t out_q, out_d, spare_q, spare_d;
  logic   out_valid_q, out_valid_d, spare_valid_q, spare_valid_d;
  logic   pop_out;
  logic [IdxW+BsizeW-1:0] offset;

  assign offset = (IdxW+BsizeW)'(push_idx_i) * (IdxW+BsizeW)'(block_size_i);

  always_comb begin
    new_entry.idx    = push_res_i.granted ? BlkIdxW'(push_idx_i) : '0;
    new_entry.addr   = push_res_i.granted ? (AddrW'(pool_base_i) + AddrW'(offset)) : '0;
    new_entry.status = push_res_i.status;
    new_entry.used   = push_res_i.used;
  end

  assign pop_out      = out_valid_q & out_ready_i;
  assign push_ready_o = ~spare_valid_q;

  always_comb begin
    out_d         = out_q;
    spare_d       = spare_q;
    out_valid_d   = out_valid_q;
    spare_valid_d = spare_valid_q;
    if (pop_out && spare_valid_q) begin
      out_d         = spare_q;
      spare_valid_d = 1'b0;
    end else if (push_i) begin
      if (out_valid_q && !pop_out) begin
        spare_d       = new_entry;
        spare_valid_d = 1'b1;
      end else begin
        out_d       = new_entry;
        out_valid_d = 1'b1;
      end
    end else if (pop_out) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
    end else begin
      out_valid_q   <= out_valid_d;
      spare_valid_q <= spare_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    spare_q <= spare_d;
  end

  assign out_valid_o       = out_valid_q;
  assign granted_index_o   = out_q.idx;
  assign granted_address_o = out_q.addr;
  assign status_o          = out_q.status;
  assign blocks_used_o     = out_q.used;

endmodule
`default_nettype wire

[rtl/core/fixed_block_free_list_allocator.sv]
// Fixed-size block pool allocator with a free stack kept in a link memory.
//
// Input channel (in_valid_i/in_ready_o) carries one request per beat: allocate,
// free a block or clear the pool. Every request yields exactly one result beat
// on the output channel (out_valid_o/out_ready_i): the granted block index, its
// byte address (pool_base plus index times block size), a status code and the
// number of blocks in use after the request.
// An allocate that pops a freed block reads the next link from the link RAM,
// whose read data is registered, so it passes through ST_POP before the block
// takes another request; other requests are handled in the cycle they are
// accepted. A two-entry result buffer lets a new request be taken while a
// finished result is still waiting; when both entries are full, in_ready_o
// falls until the receiver takes a beat, and nothing is lost. Reset empties
// the free stack, restarts fresh allocation at block zero and clears the usage
// count; the link RAM needs no clearing pass, as a link is only read after a
// free has written it. Configuration (pool base, block size) is written through
// cfg_we_i/cfg_index_i/cfg_wdata_i; the user must do so only while the block
// is idle, as the block itself does not enforce it.
`default_nettype none
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int NumBlocks = NumBlocksDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [ActionW-1:0]  action_i,
  input  wire logic [BlkIdxW-1:0]  block_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [BlkIdxW-1:0]       granted_index_o,
  output logic [AddrW-1:0]         granted_address_o,
  output logic [StatusW-1:0]       status_o,
  output logic [UsedW-1:0]         blocks_used_o
);

  localparam int IdxW  = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int HeadW = $clog2(NumBlocks + 1);
  localparam logic [HeadW-1:0] StackEmpty = HeadW'(NumBlocks);

  logic [BaseW-1:0]  pool_base_q;
  logic [BsizeW-1:0] block_size_q;

  state_e state_q, state_d;
  logic [HeadW-1:0]    head_q, head_d;
  logic [HeadW-1:0]    fresh_q, fresh_d;
  logic [UsedCntW-1:0] used_q, used_d;
  logic [IdxW-1:0]     pop_idx_q;

  logic             accept;
  logic             buf_ready;
  logic             push;
  logic [IdxW-1:0]  push_idx;
  res_t             push_res;
  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr;
  logic [HeadW-1:0] ram_rdata;
  logic             blk_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      block_size_q <= BsizeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POOL_BASE:  pool_base_q  <= cfg_wdata_i;
        CFG_BLOCK_SIZE: block_size_q <= cfg_wdata_i[BsizeW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE) && buf_ready;
  assign accept       = in_valid_i && in_ready_o;
  assign blk_in_range = 32'(block_index_i) < 32'(NumBlocks);
  assign ram_waddr    = IdxW'(block_index_i);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    fresh_d  = fresh_q;
    used_d   = used_q;
    push     = 1'b0;
    push_idx = '0;
    push_res = '{granted: 1'b0, status: STAT_OK, used: UsedW'(used_q)};
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_ALLOC: begin
              if (head_q < StackEmpty) begin
                // The next link arrives from the RAM in the following cycle.
                ram_re  = 1'b1;
                state_d = ST_POP;
              end else if (fresh_q < StackEmpty) begin
                push             = 1'b1;
                push_idx         = fresh_q[IdxW-1:0];
                fresh_d          = fresh_q + HeadW'(1);
                used_d           = used_q + UsedCntW'(1);
                push_res.granted = 1'b1;
                push_res.used    = UsedW'(used_d);
              end else begin
                push            = 1'b1;
                push_res.status = STAT_OOM;
              end
            end
            ACT_FREE: begin
              push = 1'b1;
              if (!blk_in_range || used_q == '0) begin
                push_res.status = STAT_BAD;
              end else begin
                ram_we        = 1'b1;
                head_d        = HeadW'(block_index_i);
                used_d        = used_q - UsedCntW'(1);
                push_res.used = UsedW'(used_d);
              end
            end
            ACT_CLEAR: begin
              push          = 1'b1;
              head_d        = StackEmpty;
              fresh_d       = '0;
              used_d        = '0;
              push_res.used = '0;
            end
            default: begin
              push            = 1'b1;
              push_res.status = STAT_BAD;
            end
          endcase
        end
      end
      ST_POP: begin
        push             = 1'b1;
        push_idx         = pop_idx_q;
        head_d           = ram_rdata;
        used_d           = used_q + UsedCntW'(1);
        push_res.granted = 1'b1;
        push_res.used    = UsedW'(used_d);
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= StackEmpty;
      fresh_q <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fresh_q <= fresh_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      pop_idx_q <= head_q[IdxW-1:0];
    end
  end

  fbfl_ram #(
    .Width(HeadW),
    .Depth(NumBlocks)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(head_q),
    .re_i   (ram_re),
    .raddr_i(head_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  fbfl_out_buf #(
    .IdxW(IdxW)
  ) u_out_buf (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pool_base_i      (pool_base_q),
    .block_size_i     (block_size_q),
    .push_i           (push),
    .push_ready_o     (buf_ready),
    .push_idx_i       (push_idx),
    .push_res_i       (push_res),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .granted_index_o  (granted_index_o),
    .granted_address_o(granted_address_o),
    .status_o         (status_o),
    .blocks_used_o    (blocks_used_o)
  );

endmodule
`default_nettype wire
